// ----- hdl/dll_pkg.sv -----
// Shared types and codes for the doubly linked list manager.
// Used by the controller, the datapath, the top level and the checker.
package dll_pkg;

    localparam int NODES_DEF = 256;

    localparam int REQ_W    = 3;
    localparam int HANDLE_W = 8;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int OP_W     = 4;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UNLINK     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_INDEX      = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_PUSH_NEW  = 4'd2;
    localparam logic [OP_W-1:0] OP_PUSH_LINK = 4'd3;
    localparam logic [OP_W-1:0] OP_RD_TAIL   = 4'd4;
    localparam logic [OP_W-1:0] OP_RD_HEAD   = 4'd5;
    localparam logic [OP_W-1:0] OP_RD_HANDLE = 4'd6;
    localparam logic [OP_W-1:0] OP_UNLINK    = 4'd7;
    localparam logic [OP_W-1:0] OP_WALK_STEP = 4'd8;
    localparam logic [OP_W-1:0] OP_CLR_TGT   = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] status;
        logic                out_load;
    } dll_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             in_pool;
        logic             member;
        logic             cnt_zero;
        logic             pos_oor;
        logic             walk_hit;
        logic             tgt_nil;
        logic             out_free;
    } dll_sts_t;

endpackage

// ----- hdl/doubly_linked_list_manager.sv -----
// Top level of the doubly linked list manager.
// Depends on dll_pkg, dll_ctrl and dll_dp (which holds the two link RAMs).
//
//   port group   dir  handshake           word
//   request      in   in_valid/in_stall   req_type, node_handle, position
//   result       out  out_valid/out_stall status, result_handle, node_count, is_empty
//
// Push, pop and unlink pass through the decode, operation and finish states
// before the next word can be taken; by-index replaces the operation state
// with a walk of the next-link RAM, link by link. Refused requests and unused
// codes skip the middle step.
// One request is in flight at a time; in_stall is high from accept until the
// result is loaded into the output register.
// Reset leaves an empty list and no result pending; the link RAMs need no clear.
// A stalled result holds the output register and delays loading the next one.
module doubly_linked_list_manager
    import dll_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [HANDLE_W-1:0] node_handle,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [HANDLE_W-1:0] result_handle,
    output logic [COUNT_W-1:0]  node_count,
    output logic                is_empty
);

    dll_cmd_t cmd;
    dll_sts_t sts;

    dll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dll_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_type      (req_type),
        .node_handle   (node_handle),
        .position      (position),
        .cmd           (cmd),
        .sts           (sts),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .result_handle (result_handle),
        .node_count    (node_count),
        .is_empty      (is_empty)
    );

endmodule

// ----- hdl/dll_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module dll_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/dll_ctrl.sv -----
// Controller state machine for the list manager.
// Depends on dll_pkg; drives the datapath through dll_cmd_t.
module dll_ctrl
    import dll_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dll_sts_t sts,
    output dll_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_PUSH   = 3'd2;
    localparam logic [2:0] S_UNLINK = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [OP_W-1:0]     op;
    logic                out_load;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        op          = OP_NONE;
        out_load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op          = OP_LOAD;
                    status_next = ST_OK;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.req)
                    REQ_PUSH_BACK, REQ_PUSH_FRONT:
                    begin
                        if (!sts.in_pool || sts.member)
                        begin
                            status_next = ST_BAD;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            op         = OP_PUSH_NEW;
                            state_next = S_PUSH;
                        end
                    end
                    REQ_POP_BACK, REQ_POP_FRONT:
                    begin
                        if (sts.cnt_zero)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            op         = (sts.req == REQ_POP_BACK) ? OP_RD_TAIL : OP_RD_HEAD;
                            state_next = S_UNLINK;
                        end
                    end
                    REQ_UNLINK:
                    begin
                        if (!sts.member)
                        begin
                            status_next = ST_BAD;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            op         = OP_RD_HANDLE;
                            state_next = S_UNLINK;
                        end
                    end
                    REQ_INDEX:
                    begin
                        if (sts.pos_oor)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            op         = OP_RD_HEAD;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        op         = OP_CLR_TGT;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_PUSH:
            begin
                op         = OP_PUSH_LINK;
                state_next = S_FINISH;
            end
            S_UNLINK:
            begin
                op         = OP_UNLINK;
                state_next = S_FINISH;
            end
            S_WALK:
            begin
                // one link per cycle until the position is reached
                if (sts.tgt_nil)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_FINISH;
                end
                else if (sts.walk_hit)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    op = OP_WALK_STEP;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (sts.out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cmd.op       = op;
    assign cmd.status   = status_reg;
    assign cmd.out_load = out_load;

endmodule

// ----- hdl/dll_dp.sv -----
// Datapath: request registers, head/tail/count, membership flops, link RAMs
// and the output register. Depends on dll_pkg and dll_ram.
module dll_dp
    import dll_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [HANDLE_W-1:0] node_handle,
    input  logic [POS_W-1:0]    position,
    input  dll_cmd_t            cmd,
    output dll_sts_t            sts,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [STATUS_W-1:0] status,
    output logic [HANDLE_W-1:0] result_handle,
    output logic [COUNT_W-1:0]  node_count,
    output logic                is_empty
);

    localparam int AW    = $clog2(NODES);
    localparam int LW    = $clog2(NODES + 1);
    localparam int MAP_N = (NODES < 256) ? NODES : 256;
    localparam int MW    = $clog2(MAP_N);
    localparam logic [LW-1:0] NIL = LW'(NODES);

    logic [REQ_W-1:0]    req_reg;
    logic [HANDLE_W-1:0] hdl_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [LW-1:0]       tgt_reg, tgt_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       tail_reg, tail_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [MAP_N-1:0]    map_reg, map_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [COUNT_W-1:0]  node_count_reg;
    logic                is_empty_reg;

    logic          nxt_we, prv_we;
    logic [AW-1:0] nxt_addr, prv_addr;
    logic [LW-1:0] nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;

    logic [LW-1:0] h_link;
    logic          push_back;
    logic          cnt_zero;
    logic          p_nil, n_nil;

    assign h_link    = LW'(hdl_reg);
    assign push_back = (req_reg == REQ_PUSH_BACK);
    assign cnt_zero  = (count_reg == '0);
    assign p_nil     = (prv_rdata >= NIL);
    assign n_nil     = (nxt_rdata >= NIL);

    assign sts.req      = req_reg;
    assign sts.in_pool  = (int'(hdl_reg) < NODES);
    assign sts.member   = sts.in_pool && map_reg[MW'(hdl_reg)];
    assign sts.cnt_zero = cnt_zero;
    assign sts.pos_oor  = ({1'b0, pos_reg} >= count_reg);
    assign sts.walk_hit = (idx_reg == pos_reg);
    assign sts.tgt_nil  = (tgt_reg >= NIL);
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        tgt_next   = tgt_reg;
        idx_next   = idx_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        map_next   = map_reg;
        nxt_we     = 1'b0;
        prv_we     = 1'b0;
        nxt_addr   = AW'(tgt_reg);
        prv_addr   = AW'(tgt_reg);
        nxt_wdata  = NIL;
        prv_wdata  = NIL;
        case (cmd.op)
            OP_PUSH_NEW:
            begin
                tgt_next  = h_link;
                nxt_we    = 1'b1;
                prv_we    = 1'b1;
                nxt_addr  = AW'(h_link);
                prv_addr  = AW'(h_link);
                nxt_wdata = push_back ? NIL : head_reg;
                prv_wdata = push_back ? tail_reg : NIL;
            end
            OP_PUSH_LINK:
            begin
                // hook the old end node onto the new one
                nxt_we    = push_back && !cnt_zero;
                prv_we    = !push_back && !cnt_zero;
                nxt_addr  = AW'(tail_reg);
                prv_addr  = AW'(head_reg);
                nxt_wdata = h_link;
                prv_wdata = h_link;
                if (push_back)
                begin
                    tail_next = h_link;
                    if (cnt_zero)
                    begin
                        head_next = h_link;
                    end
                end
                else
                begin
                    head_next = h_link;
                    if (cnt_zero)
                    begin
                        tail_next = h_link;
                    end
                end
                map_next[MW'(h_link)] = 1'b1;
                count_next            = count_reg + COUNT_W'(1);
            end
            OP_RD_TAIL:
            begin
                tgt_next = tail_reg;
                nxt_addr = AW'(tail_reg);
                prv_addr = AW'(tail_reg);
            end
            OP_RD_HEAD:
            begin
                tgt_next = head_reg;
                idx_next = '0;
                nxt_addr = AW'(head_reg);
                prv_addr = AW'(head_reg);
            end
            OP_RD_HANDLE:
            begin
                tgt_next = h_link;
                nxt_addr = AW'(h_link);
                prv_addr = AW'(h_link);
            end
            OP_UNLINK:
            begin
                // bridge the neighbors of the target
                nxt_we    = !p_nil;
                prv_we    = !n_nil;
                nxt_addr  = AW'(prv_rdata);
                prv_addr  = AW'(nxt_rdata);
                nxt_wdata = nxt_rdata;
                prv_wdata = prv_rdata;
                if (p_nil)
                begin
                    head_next = nxt_rdata;
                end
                if (n_nil)
                begin
                    tail_next = prv_rdata;
                end
                map_next[MW'(tgt_reg)] = 1'b0;
                if (!cnt_zero)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_WALK_STEP:
            begin
                // follow the link read last cycle and fetch the one after it
                tgt_next = nxt_rdata;
                idx_next = idx_reg + POS_W'(1);
                nxt_addr = AW'(nxt_rdata);
                prv_addr = AW'(nxt_rdata);
            end
            OP_CLR_TGT:
            begin
                tgt_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NIL;
            tail_reg      <= NIL;
            count_reg     <= '0;
            map_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next;
        idx_reg <= idx_next;
        if (cmd.op == OP_LOAD)
        begin
            req_reg <= req_type;
            hdl_reg <= node_handle;
            pos_reg <= position;
        end
        if (cmd.out_load)
        begin
            status_reg     <= cmd.status;
            handle_reg     <= (cmd.status == ST_OK) ? HANDLE_W'(tgt_reg) : '0;
            node_count_reg <= count_reg;
            is_empty_reg   <= cnt_zero;
        end
    end

    dll_ram #(
        .WIDTH (LW),
        .DEPTH (NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .addr  (nxt_addr),
        .wdata (nxt_wdata),
        .rdata (nxt_rdata)
    );

    dll_ram #(
        .WIDTH (LW),
        .DEPTH (NODES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .addr  (prv_addr),
        .wdata (prv_wdata),
        .rdata (prv_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_handle = handle_reg;
    assign node_count    = node_count_reg;
    assign is_empty      = is_empty_reg;

endmodule

// ----- hdl/dll_checker.sv -----
// Port-level checks for the list manager, bound to the top level.
// Depends on dll_pkg.
module dll_checker
    import dll_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [STATUS_W-1:0] status,
    input logic [HANDLE_W-1:0] result_handle,
    input logic [COUNT_W-1:0]  node_count,
    input logic                is_empty
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(result_handle) && $stable(node_count) && $stable(is_empty))
        else $error("stalled result word changed");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (node_count == '0)))
        else $error("is_empty disagrees with node_count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (result_handle == '0))
        else $error("failed request returned a handle");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (node_count == '0))
        else $error("empty status with nonzero count");

    // one request at a time: stall right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while busy");

endmodule

bind doubly_linked_list_manager dll_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .result_handle (result_handle),
    .node_count    (node_count),
    .is_empty      (is_empty)
);

// ----- dv/tb.sv -----
// Self-checking testbench for doubly_linked_list_manager: a directed table, then
// random push/pop/unlink/index traffic and unused codes, checked against an in-bench list model.
// Depends on dll_pkg and the doubly_linked_list_manager RTL.
module tb;
    import dll_pkg::*;

    localparam int          LIMIT_CYCLES  = 1_500_000;
    localparam int          RANDOM_WORDS  = 950;
    localparam int          OPENING_WORDS = 25;
    localparam logic [8:0]  NIL           = 9'd256;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [HANDLE_W-1:0] hnd;
        logic [COUNT_W-1:0]  cnt;
        logic                emp;
    } reply_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [HANDLE_W-1:0] hnd;
        logic [POS_W-1:0]    pos;
        logic                typed;
        reply_t              want;
    } opening_row_t;

    typedef enum logic [1:0] {GROW, SHRINK, MIXED} traffic_t;

    localparam reply_t NO_TYPED = '0;

    // typed rows carry their expected reply in the table; the rest use the model
    localparam opening_row_t OPENING_ROWS [0:OPENING_WORDS-1] = '{
        '{REQ_POP_BACK,   8'h00, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 9'd0, 1'b1}},
        '{REQ_POP_FRONT,  8'h00, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 9'd0, 1'b1}},
        '{REQ_INDEX,      8'h00, 8'h00, 1'b1, '{ST_RANGE, 8'h00, 9'd0, 1'b1}},
        '{REQ_INDEX,      8'h00, 8'hFF, 1'b1, '{ST_RANGE, 8'h00, 9'd0, 1'b1}},
        '{REQ_UNLINK,     8'h00, 8'h00, 1'b1, '{ST_BAD,   8'h00, 9'd0, 1'b1}},
        '{REQ_PUSH_BACK,  8'h00, 8'h00, 1'b1, '{ST_OK,    8'h00, 9'd1, 1'b0}},
        '{REQ_PUSH_BACK,  8'h00, 8'h00, 1'b1, '{ST_BAD,   8'h00, 9'd1, 1'b0}},
        '{REQ_PUSH_FRONT, 8'hFF, 8'h00, 1'b1, '{ST_OK,    8'hFF, 9'd2, 1'b0}},
        '{REQ_PUSH_FRONT, 8'hFF, 8'h00, 1'b1, '{ST_BAD,   8'h00, 9'd2, 1'b0}},
        '{REQ_PUSH_BACK,  8'hA5, 8'h00, 1'b0, NO_TYPED},
        '{REQ_PUSH_FRONT, 8'h5A, 8'h00, 1'b0, NO_TYPED},
        '{REQ_INDEX,      8'h00, 8'h00, 1'b0, NO_TYPED},
        '{REQ_INDEX,      8'h00, 8'h03, 1'b0, NO_TYPED},
        '{REQ_INDEX,      8'h00, 8'h04, 1'b1, '{ST_RANGE, 8'h00, 9'd4, 1'b0}},
        '{REQ_INDEX,      8'h00, 8'hFF, 1'b1, '{ST_RANGE, 8'h00, 9'd4, 1'b0}},
        '{REQ_UNLINK,     8'h00, 8'h00, 1'b0, NO_TYPED},
        '{REQ_UNLINK,     8'h00, 8'h00, 1'b1, '{ST_BAD,   8'h00, 9'd3, 1'b0}},
        '{REQ_SPARE_6,    8'hFF, 8'hFF, 1'b0, NO_TYPED},
        '{REQ_SPARE_7,    8'h5A, 8'h00, 1'b0, NO_TYPED},
        '{REQ_INDEX,      8'h00, 8'h02, 1'b0, NO_TYPED},
        '{REQ_POP_BACK,   8'h00, 8'h00, 1'b0, NO_TYPED},
        '{REQ_POP_FRONT,  8'h00, 8'h00, 1'b0, NO_TYPED},
        '{REQ_POP_BACK,   8'h00, 8'h00, 1'b0, NO_TYPED},
        '{REQ_POP_FRONT,  8'h00, 8'h00, 1'b1, '{ST_EMPTY, 8'h00, 9'd0, 1'b1}},
        '{REQ_UNLINK,     8'hFF, 8'h00, 1'b1, '{ST_BAD,   8'h00, 9'd0, 1'b1}}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type;
    logic [HANDLE_W-1:0] node_handle;
    logic [POS_W-1:0]    position;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] result_handle;
    logic [COUNT_W-1:0]  node_count;
    logic                is_empty;

    // list model state
    logic [8:0] nxt_link [0:255];
    logic [8:0] prv_link [0:255];
    logic       on_list  [0:255];
    logic [8:0] head;
    logic [8:0] tail;
    logic [8:0] list_len;

    reply_t replies_due [$];
    int     mismatches;
    int     words_sent;
    int     cycle_cnt;
    bit     calm;
    bit     gaps_on;

    doubly_linked_list_manager dut (.*);

    always #4 clk = ~clk;

    function automatic void drop_from_list(logic [7:0] h);
        logic [8:0] p;
        logic [8:0] n;
        p = prv_link[h];
        n = nxt_link[h];
        if (p == NIL)
            head = n;
        else
            nxt_link[p[7:0]] = n;
        if (n == NIL)
            tail = p;
        else
            prv_link[n[7:0]] = p;
        on_list[h] = 1'b0;
        list_len   = list_len - 9'd1;
    endfunction

    function automatic reply_t apply_to_list(logic [2:0] req, logic [7:0] h, logic [7:0] pos);
        reply_t     r;
        logic [8:0] cur;
        r = '0;
        case (req)
            REQ_PUSH_BACK, REQ_PUSH_FRONT:
            begin
                if (on_list[h])
                    r.st = ST_BAD;
                else
                begin
                    if (req == REQ_PUSH_BACK)
                    begin
                        prv_link[h] = tail;
                        nxt_link[h] = NIL;
                        if (list_len == 0)
                            head = {1'b0, h};
                        else
                            nxt_link[tail[7:0]] = {1'b0, h};
                        tail = {1'b0, h};
                    end
                    else
                    begin
                        prv_link[h] = NIL;
                        nxt_link[h] = head;
                        if (list_len == 0)
                            tail = {1'b0, h};
                        else
                            prv_link[head[7:0]] = {1'b0, h};
                        head = {1'b0, h};
                    end
                    on_list[h] = 1'b1;
                    list_len   = list_len + 9'd1;
                    r.hnd      = h;
                end
            end
            REQ_POP_BACK, REQ_POP_FRONT:
            begin
                if (list_len == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    cur = (req == REQ_POP_BACK) ? tail : head;
                    drop_from_list(cur[7:0]);
                    r.hnd = cur[7:0];
                end
            end
            REQ_UNLINK:
            begin
                if (!on_list[h])
                    r.st = ST_BAD;
                else
                begin
                    drop_from_list(h);
                    r.hnd = h;
                end
            end
            REQ_INDEX:
            begin
                if ({1'b0, pos} >= list_len)
                    r.st = ST_RANGE;
                else
                begin
                    cur = head;
                    for (int i = 0; i < pos; i++)
                        cur = nxt_link[cur[7:0]];
                    r.hnd = cur[7:0];
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = list_len;
        r.emp = (list_len == 0);
        return r;
    endfunction

    function automatic logic [7:0] free_handle_from(logic [7:0] start);
        logic [7:0] h;
        h = start;
        for (int i = 0; i < 256; i++)
        begin
            if (!on_list[h])
                return h;
            h = h + 8'd1;
        end
        return start;
    endfunction

    function automatic logic [7:0] member_handle_from(logic [7:0] start);
        logic [7:0] h;
        h = start;
        for (int i = 0; i < 256; i++)
        begin
            if (on_list[h])
                return h;
            h = h + 8'd1;
        end
        return start;
    endfunction

    // present one word, hold it until taken, then log what the list must answer
    task automatic send_request(input logic [2:0] req, input logic [7:0] h,
                                input logic [7:0] pos, input logic typed, input reply_t want);
        reply_t r;
        in_valid    <= 1'b1;
        req_type    <= req;
        node_handle <= h;
        position    <= pos;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_to_list(req, h, pos);
        replies_due.push_back(typed ? want : r);
        words_sent++;
        if (!calm && gaps_on && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic pick_request(input traffic_t mode, output logic [2:0] req,
                                output logic [7:0] h, output logic [7:0] pos);
        int roll;
        int kind;
        h    = 8'($urandom);
        pos  = 8'($urandom);
        req  = 3'($urandom_range(0, 7));
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return;
        roll = $urandom_range(0, 99);
        // kind: 0 push, 1 pop, 2 unlink, 3 index
        case (mode)
            GROW:    kind = roll < 65 ? 0 : roll < 80 ? 3 : roll < 90 ? 1 : 2;
            SHRINK:  kind = roll < 45 ? 1 : roll < 70 ? 2 : roll < 90 ? 3 : 0;
            default: kind = roll / 25;
        endcase
        case (kind)
            0:
            begin
                req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                h   = free_handle_from(h);
            end
            1:
                req = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
            2:
            begin
                req = REQ_UNLINK;
                if (list_len != 0)
                    h = member_handle_from(h);
            end
            default:
            begin
                req = REQ_INDEX;
                if (list_len != 0)
                    pos = 8'($urandom_range(0, list_len - 1));
            end
        endcase
    endtask

    // receiver side: stall bursts, with stretches of none
    always @(posedge clk)
    begin
        int  stall_left;
        bit  stall_on;
        if ($urandom_range(0, 199) == 0)
            stall_on = !stall_on;
        if (calm)
            out_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (stall_on && $urandom_range(0, 99) < 15)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 10);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{status, result_handle, node_count, is_empty};
            if (replies_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: st=%0d hnd=%0d cnt=%0d emp=%0d",
                             got.st, got.hnd, got.cnt, got.emp);
            end
            else
            begin
                want = replies_due.pop_front();
                if (got.st !== want.st || got.hnd !== want.hnd ||
                    got.cnt !== want.cnt || got.emp !== want.emp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d hnd=%0d cnt=%0d emp=%0d, ",
                                  "got st=%0d hnd=%0d cnt=%0d emp=%0d"},
                                 want.st, want.hnd, want.cnt, want.emp,
                                 got.st, got.hnd, got.cnt, got.emp);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("** doubly_linked_list_manager: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] req;
        logic [7:0] h;
        logic [7:0] pos;
        traffic_t   mode;
        int         seg_len;
        bit         filled;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        req_type    = '0;
        node_handle = '0;
        position    = '0;
        mismatches  = 0;
        words_sent  = 0;
        cycle_cnt   = 0;
        calm        = 1'b0;
        gaps_on     = 1'b1;
        filled      = 1'b0;
        head        = NIL;
        tail        = NIL;
        list_len    = '0;
        for (int i = 0; i < 256; i++)
            on_list[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING_ROWS[i])
            send_request(OPENING_ROWS[i].req, OPENING_ROWS[i].hnd, OPENING_ROWS[i].pos,
                         OPENING_ROWS[i].typed, OPENING_ROWS[i].want);

        while (words_sent < OPENING_WORDS + RANDOM_WORDS)
        begin
            if (!filled && words_sent >= 300)
            begin
                // drain everything, then fill the pool to the last handle
                filled = 1'b1;
                in_valid <= 1'b0;
                while (replies_due.size() != 0)
                    @(posedge clk);
                while (list_len < 9'd256)
                    send_request($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                                 free_handle_from(8'($urandom)), 8'($urandom), 1'b0, NO_TYPED);
                send_request(REQ_INDEX, 8'($urandom), 8'hFF, 1'b0, NO_TYPED);
                send_request(REQ_INDEX, 8'($urandom), 8'h00, 1'b0, NO_TYPED);
                send_request(REQ_PUSH_BACK, 8'($urandom), 8'h00, 1'b0, NO_TYPED);
                mode = SHRINK;
            end
            else
                mode = traffic_t'($urandom_range(0, 2));
            gaps_on = $urandom_range(0, 3) != 0;
            seg_len = $urandom_range(15, 60);
            repeat (seg_len)
            begin
                calm = words_sent >= OPENING_WORDS + RANDOM_WORDS - 100;
                pick_request(mode, req, h, pos);
                send_request(req, h, pos, 1'b0, NO_TYPED);
            end
        end
        in_valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("** doubly_linked_list_manager: PASSED **");
        else
            $display("** doubly_linked_list_manager: FAILED **");
        $finish;
    end

endmodule
